### hw/rtl/chs_pkg.sv
package chs_pkg;

    localparam int MAG_W       = 16;
    localparam int DECL_W      = 14;
    localparam int HEADING_W   = 15;

    localparam int ANGLE_STEPS = 16;
    localparam int TABLE_LEN   = 24;
    localparam int STEPS       = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;

    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = (STEPS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

    localparam int FRAC_SHIFT  = 8;
    localparam int EXT_W       = MAG_W + 1;
    localparam int VEC_W       = 27;
    localparam int ANG_W       = 27;
    localparam int DECL_SHIFT  = 10;
    localparam int SUM_W       = 29;
    localparam int H_W         = SUM_W - DECL_SHIFT;

    localparam logic signed [ANG_W-1:0]  HALF_TURN_Q16 = 27'sd11796480;
    localparam logic signed [H_W-1:0]    FULL_TURN_Q6  = 19'sd23040;
    localparam logic signed [SUM_W-1:0]  ROUND_HALF    = 29'sd512;
    localparam logic signed [DECL_W-1:0] DECL_RESET    = 14'sd770;

    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = 27'sd2949120;
            1:       r = 27'sd1740967;
            2:       r = 27'sd919879;
            3:       r = 27'sd466945;
            4:       r = 27'sd234379;
            5:       r = 27'sd117304;
            6:       r = 27'sd58666;
            7:       r = 27'sd29335;
            8:       r = 27'sd14668;
            9:       r = 27'sd7334;
            10:      r = 27'sd3667;
            11:      r = 27'sd1833;
            12:      r = 27'sd917;
            13:      r = 27'sd458;
            14:      r = 27'sd229;
            15:      r = 27'sd115;
            16:      r = 27'sd57;
            17:      r = 27'sd29;
            18:      r = 27'sd14;
            19:      r = 27'sd7;
            20:      r = 27'sd4;
            21:      r = 27'sd2;
            22:      r = 27'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/chs_if.sv
interface chs_mag_if;
    import chs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MAG_W-1:0] mag_x;
    logic signed [MAG_W-1:0] mag_y;

    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface chs_heading_if;
    import chs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

### hw/rtl/chs_prerot.sv
module chs_prerot (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [chs_pkg::MAG_W-1:0] mag_x,
    input  logic signed [chs_pkg::MAG_W-1:0] mag_y,
    output logic                             out_valid,
    output chs_pkg::cordic_t                 out_data
);
    import chs_pkg::*;

    logic signed [EXT_W-1:0] x_ext;
    logic signed [EXT_W-1:0] v_ext;
    logic signed [EXT_W-1:0] x_rot;
    logic signed [EXT_W-1:0] y_rot;
    logic                    valid_reg;
    cordic_t                 data_reg;
    cordic_t                 data_next;

    always_comb
    begin
        x_ext = {mag_x[MAG_W-1], mag_x};
        v_ext = -{mag_y[MAG_W-1], mag_y};
        data_next.zero = (mag_x == '0) && (mag_y == '0);
        if (x_ext[EXT_W-1])
        begin
            x_rot = -x_ext;
            y_rot = -v_ext;
            data_next.z = v_ext[EXT_W-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
        end
        else
        begin
            x_rot = x_ext;
            y_rot = v_ext;
            data_next.z = '0;
        end
        data_next.x = {{(VEC_W-EXT_W-FRAC_SHIFT){x_rot[EXT_W-1]}}, x_rot, {FRAC_SHIFT{1'b0}}};
        data_next.y = {{(VEC_W-EXT_W-FRAC_SHIFT){y_rot[EXT_W-1]}}, y_rot, {FRAC_SHIFT{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

### hw/rtl/chs_cordic_pipe.sv
module chs_cordic_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  chs_pkg::cordic_t in_data,
    output logic             out_valid,
    output chs_pkg::cordic_t out_data
);
    import chs_pkg::*;

    cordic_t data_reg  [CORDIC_STAGES];
    logic    valid_reg [CORDIC_STAGES];

    function automatic cordic_t cordic_iters(input cordic_t d, input int first);
        cordic_t                 r;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        int                      i;
        x = d.x;
        y = d.y;
        z = d.z;
        for (int j = 0; j < ITERS_PER_STAGE; j++)
        begin
            i = first + j;
            if (i < STEPS)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (!y[VEC_W-1])
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_entry(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_entry(i);
                end
            end
        end
        r.zero = d.zero;
        r.x    = x;
        r.y    = y;
        r.z    = z;
        return r;
    endfunction

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        cordic_t stage_in;
        logic    stage_valid;

        if (s == 0)
        begin : g_first
            assign stage_in    = in_data;
            assign stage_valid = in_valid;
        end
        else
        begin : g_rest
            assign stage_in    = data_reg[s-1];
            assign stage_valid = valid_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= stage_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                data_reg[s] <= cordic_iters(stage_in, s * ITERS_PER_STAGE);
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_data  = data_reg[CORDIC_STAGES-1];
endmodule

### hw/rtl/chs_finish.sv
module chs_finish (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  chs_pkg::cordic_t                  in_data,
    input  logic signed [chs_pkg::DECL_W-1:0] declination,
    output logic                              out_valid,
    output logic [chs_pkg::HEADING_W-1:0]     heading
);
    import chs_pkg::*;

    logic signed [SUM_W-1:0] angle_ext;
    logic signed [SUM_W-1:0] decl_ext;
    logic signed [SUM_W-1:0] total;
    logic signed [H_W-1:0]   h_raw;
    logic signed [H_W-1:0]   h_wrap;
    logic                    valid_reg;
    logic [HEADING_W-1:0]    heading_reg;
    logic [HEADING_W-1:0]    heading_next;

    always_comb
    begin
        if (in_data.zero)
            angle_ext = '0;
        else
            angle_ext = {{(SUM_W-ANG_W){in_data.z[ANG_W-1]}}, in_data.z};
        decl_ext = {{(SUM_W-DECL_W-DECL_SHIFT){declination[DECL_W-1]}}, declination,
                    {DECL_SHIFT{1'b0}}};
        total    = angle_ext + decl_ext + ROUND_HALF;
        h_raw    = total[SUM_W-1:DECL_SHIFT];
        if (h_raw[H_W-1] || (h_raw == '0))
            h_wrap = h_raw + FULL_TURN_Q6;
        else
            h_wrap = h_raw;
        heading_next = h_wrap[HEADING_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            heading_reg <= heading_next;
    end

    assign out_valid = valid_reg;
    assign heading   = heading_reg;
endmodule

### hw/rtl/compass_heading_from_magnetometer_core.sv
// channel   dir  handshake     word
// sample    in   valid/ready   mag_x[15:0] signed, mag_y[15:0] signed
// result    out  valid/ready   heading[14:0], 1/64 degree, in (0, 360]
// cfg       in   cfg_we        cfg_wdata[13:0] signed declination, 1/64 degree
//
// One word per cycle while the result is not held; samples pass through the pre-rotation
// register, the CORDIC pipeline at two iterations per stage and the finish register.
// Reset clears all valid bits; declination resets to 770.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module compass_heading_from_magnetometer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic signed [chs_pkg::DECL_W-1:0] cfg_wdata,
    chs_mag_if.sink                           sample,
    chs_heading_if.source                     result
);
    import chs_pkg::*;

    logic                     en;
    logic signed [DECL_W-1:0] decl_reg;
    logic                     pre_valid;
    cordic_t                  pre_data;
    logic                     cor_valid;
    cordic_t                  cor_data;

    // advance unless the result word is held
    assign en           = !result.valid || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= DECL_RESET;
        else if (cfg_we)
            decl_reg <= cfg_wdata;
    end

    chs_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .mag_x     (sample.mag_x),
        .mag_y     (sample.mag_y),
        .out_valid (pre_valid),
        .out_data  (pre_data)
    );

    chs_cordic_pipe u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_data   (pre_data),
        .out_valid (cor_valid),
        .out_data  (cor_data)
    );

    chs_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (cor_valid),
        .in_data     (cor_data),
        .declination (decl_reg),
        .out_valid   (result.valid),
        .heading     (result.heading)
    );
endmodule
